// File: rtl/core/sorted_id_table_lookup_unit_defines.svh
// assertion macros used by the sorted id table lookup datapath
`ifndef SORTED_ID_TABLE_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_ID_TABLE_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SITL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SITL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sitl_pkg.sv
// types, codes and constants of the sorted id table lookup unit
package sitl_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_ID_W     = 32;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned STS_W       = 2;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_ID_WIDTH    = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IN_ID_W-1:0] frame_id;
  } in_data_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [STS_W-1:0] status;
  } out_data_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_INS_FULL,
    DP_INS_START,
    DP_INS_STEP,
    DP_LK_EMPTY,
    DP_LK_START,
    DP_LK_STEP,
    DP_OTHER,
    DP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } sitl_ctl_t;

  typedef struct packed {
    logic count_zero;
    logic table_full;
    logic ins_shift;
    logic lk_done;
    logic out_free;
  } sitl_sts_t;

endpackage

// File: rtl/core/sorted_id_table_lookup_unit.sv
// Sorted id table lookup unit: keeps up to TABLE_DEPTH identifiers in ascending order in a
// single-port-write, single-port-read memory, each with the load position it was inserted at.
// One transaction is worked on at a time. Clear, unused commands, inserts into a full table and
// lookups in an empty table need no table access. A lookup is a binary search with one memory
// read per probe. An insert moves entries up one slot at a time to make room for the new one.
// A finished result sits in an output register, so the next transaction is accepted while
// the result still waits to be taken. Table memory is not cleared after reset; no
// initialization pass is needed.
module sorted_id_table_lookup_unit import sitl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_data_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_data_t out_data_o
);

  sitl_ctl_t ctl;
  sitl_sts_t sts;

  sitl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  sitl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

endmodule

// File: rtl/core/sitl_dpath.sv
// datapath: sorted table memory, insert shifter, binary search and result registers
module sitl_dpath import sitl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_data_t  in_data_i,
  input  sitl_ctl_t ctl_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_data_t out_data_o,
  output sitl_sts_t sts_o
);

  `include "sorted_id_table_lookup_unit_defines.svh"

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W  = ID_WIDTH + ADDR_W;

  // each entry holds {identifier, load position}
  logic [ENT_W-1:0]    mem [TABLE_DEPTH];
  logic [ENT_W-1:0]    rd_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ENT_W-1:0]    wdata;

  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    j_q;
  logic [CNT_W-1:0]    low_q, high_q, mid_q;
  logic [ID_WIDTH-1:0] id_q;
  out_data_t           res_q;
  out_data_t           out_q;
  logic                out_valid_q;

  logic [ID_WIDTH-1:0] in_id;
  logic [ID_WIDTH-1:0] rd_id;
  logic [ADDR_W-1:0]   rd_pos;
  logic                id_lt, id_gt;
  logic                range_ok, lk_hit, lk_done, ins_shift;
  logic [CNT_W-1:0]    cnt_m1, start_mid, j_m1, j_m2;
  logic [CNT_W-1:0]    lo_nx, hi_nx, mid_nx;
  logic [CNT_W:0]      mid_sum;

  assign in_id  = ID_WIDTH'(in_data_i.frame_id);
  assign rd_id  = rd_q[ENT_W-1 -: ID_WIDTH];
  assign rd_pos = rd_q[ADDR_W-1:0];

  assign id_lt = id_q < rd_id;
  assign id_gt = id_q > rd_id;

  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign start_mid = cnt_m1 >> 1;
  assign j_m1      = j_q - CNT_W'(1);
  assign j_m2      = j_q - CNT_W'(2);

  // next search window and its midpoint
  always_comb begin
    if (id_lt) begin
      lo_nx = low_q;
      hi_nx = mid_q - CNT_W'(1);
    end else begin
      lo_nx = mid_q + CNT_W'(1);
      hi_nx = high_q;
    end
    mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
    mid_nx  = mid_sum[CNT_W:1];
  end

  // a miss ends on the probe that leaves an empty window
  assign range_ok  = low_q <= high_q;
  assign lk_hit    = range_ok && !id_lt && !id_gt;
  assign lk_done   = !range_ok || lk_hit || (id_lt && (mid_q == '0)) || (lo_nx > hi_nx);
  assign ins_shift = (j_q != '0) && id_lt;

  always_comb begin
    unique case (ctl_i.op)
      DP_INS_START: rd_addr = cnt_m1[ADDR_W-1:0];
      DP_INS_STEP:  rd_addr = j_m2[ADDR_W-1:0];
      DP_LK_START:  rd_addr = start_mid[ADDR_W-1:0];
      DP_LK_STEP:   rd_addr = mid_nx[ADDR_W-1:0];
      default:      rd_addr = '0;
    endcase
  end

  // insert step either moves the probed entry up one slot or drops the new one in
  assign we    = (ctl_i.op == DP_INS_STEP);
  assign waddr = j_q[ADDR_W-1:0];
  assign wdata = ins_shift ? rd_q : {id_q, cnt_q[ADDR_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.op == DP_CLEAR) begin
        cnt_q <= '0;
      end else if (ctl_i.op == DP_INS_STEP && !ins_shift) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ctl_i.op == DP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      DP_CLEAR: begin
        res_q <= '{entry_index: '0, status: ST_OK};
      end
      DP_INS_FULL: begin
        res_q <= '{entry_index: IDX_W'(cnt_q), status: ST_FULL};
      end
      DP_INS_START: begin
        id_q <= in_id;
        j_q  <= cnt_q;
      end
      DP_INS_STEP: begin
        if (ins_shift) begin
          j_q <= j_m1;
        end else begin
          res_q <= '{entry_index: IDX_W'(cnt_q), status: ST_OK};
        end
      end
      DP_LK_EMPTY: begin
        res_q <= '{entry_index: '0, status: ST_MISS};
      end
      DP_LK_START: begin
        id_q   <= in_id;
        low_q  <= '0;
        high_q <= cnt_m1;
        mid_q  <= start_mid;
      end
      DP_LK_STEP: begin
        if (lk_hit) begin
          res_q <= '{entry_index: IDX_W'(rd_pos), status: ST_OK};
        end else if (lk_done) begin
          res_q <= '{entry_index: IDX_W'(cnt_q), status: ST_MISS};
        end else begin
          low_q  <= lo_nx;
          high_q <= hi_nx;
          mid_q  <= mid_nx;
        end
      end
      DP_OTHER: begin
        res_q <= '{entry_index: IDX_W'(cnt_q), status: ST_OK};
      end
      DP_PUSH: begin
        out_q <= res_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.count_zero = (cnt_q == '0);
  assign sts_o.table_full = (cnt_q >= CNT_W'(TABLE_DEPTH));
  assign sts_o.ins_shift  = ins_shift;
  assign sts_o.lk_done    = lk_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `SITL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `SITL_ASSERT_IMP(a_mid_window, ctl_i.op == DP_LK_STEP && range_ok,
                   mid_q >= low_q && mid_q <= high_q, "probe outside search window")
  `SITL_ASSERT_IMP(a_push_free, ctl_i.op == DP_PUSH, !out_valid_q || out_ready_i,
                   "result pushed over a pending transaction")
  `SITL_ASSERT_NXT(a_shift_down, ctl_i.op == DP_INS_STEP && ins_shift,
                   j_q == $past(j_q) - CNT_W'(1), "insert slot did not move down")

endmodule

// File: rtl/core/sitl_ctrl.sv
// controller: sequences clear, insert and lookup operations on the datapath
module sitl_ctrl import sitl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  sitl_sts_t        sts_i,
  output logic             in_ready_o,
  output sitl_ctl_t        ctl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_LK   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    ctl_o.op  = DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DONE;
          unique case (in_cmd_i)
            CMD_CLEAR: begin
              ctl_o.op = DP_CLEAR;
            end
            CMD_INSERT: begin
              if (sts_i.table_full) begin
                ctl_o.op = DP_INS_FULL;
              end else begin
                ctl_o.op = DP_INS_START;
                state_d  = S_INS;
              end
            end
            CMD_LOOKUP: begin
              if (sts_i.count_zero) begin
                ctl_o.op = DP_LK_EMPTY;
              end else begin
                ctl_o.op = DP_LK_START;
                state_d  = S_LK;
              end
            end
            default: begin
              ctl_o.op = DP_OTHER;
            end
          endcase
        end
      end
      S_INS: begin
        ctl_o.op = DP_INS_STEP;
        if (!sts_i.ins_shift) begin
          state_d = S_DONE;
        end
      end
      S_LK: begin
        ctl_o.op = DP_LK_STEP;
        if (sts_i.lk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (sts_i.out_free) begin
          ctl_o.op = DP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: test/tb_sorted_id_table_lookup_unit.sv
// testbench of the sorted id table lookup unit: random traffic, live prediction, response checks
`timescale 1ns / 100ps

module tb_sorted_id_table_lookup_unit;
  import sitl_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 950;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    in_data_t data;
    bit       hold;  // wait for every response before sending
  } table_cmd_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_data_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_data_t out_data;

  // predictor copy of the table
  logic [IN_ID_W-1:0] tbl_ids [DEPTH];
  logic [7:0]         tbl_pos [DEPTH];
  int                 tbl_count;

  table_cmd_t         queued_cmds[$];
  out_data_t          pending_responses[$];
  logic [IN_ID_W-1:0] gen_ids[$];
  int                 gen_count;
  int                 items_made;
  int                 mismatches;
  int                 responses_seen;
  int                 send_gap;
  int                 recv_stall;
  bit                 send_quiet;
  bit                 recv_quiet;
  int                 idle_cycles;

  sorted_id_table_lookup_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected response of one command, updating the table copy
  function automatic out_data_t table_response(input in_data_t req);
    out_data_t          rsp;
    logic [IN_ID_W-1:0] key;
    int                 lo;
    int                 hi;
    int                 mid;
    int                 j;
    bit                 done;
    key = req.frame_id;
    rsp.entry_index = IDX_W'(tbl_count);
    rsp.status = ST_OK;
    case (req.command)
      CMD_CLEAR: begin
        tbl_count = 0;
        rsp.entry_index = '0;
      end
      CMD_INSERT: begin
        if (tbl_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          j = tbl_count;
          while (j > 0 && key < tbl_ids[j-1]) begin
            tbl_ids[j] = tbl_ids[j-1];
            tbl_pos[j] = tbl_pos[j-1];
            j--;
          end
          tbl_ids[j] = key;
          tbl_pos[j] = 8'(tbl_count);
          tbl_count++;
        end
      end
      CMD_LOOKUP: begin
        if (tbl_count == 0) begin
          rsp.entry_index = '0;
          rsp.status = ST_MISS;
        end else begin
          rsp.status = ST_MISS;
          lo = 0;
          hi = tbl_count - 1;
          done = 1'b0;
          while (lo <= hi && !done) begin
            mid = (lo + hi) >> 1;
            if (key < tbl_ids[mid]) begin
              if (mid == 0) done = 1'b1;
              else hi = mid - 1;
            end else if (key > tbl_ids[mid]) begin
              lo = mid + 1;
            end else begin
              rsp.entry_index = {1'b0, tbl_pos[mid]};
              rsp.status = ST_OK;
              done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // ids near what the table holds, at the extremes, or anywhere
  function automatic logic [IN_ID_W-1:0] pick_id();
    int                 r;
    logic [IN_ID_W-1:0] base;
    r = $urandom_range(0, 99);
    if (gen_ids.size() != 0) base = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    else base = $urandom;
    if (r < 30) return base;
    else if (r < 45) return $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
    else if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end else if (r < 70) return $urandom_range(0, 15);
    else return $urandom;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [IN_ID_W-1:0] id,
                         input bit hold = 1'b0);
    table_cmd_t c;
    c.data.command = cmd;
    c.data.frame_id = id;
    c.hold = hold;
    queued_cmds.push_back(c);
    if (cmd != CMD_UNUSED) items_made++;
    if (cmd == CMD_CLEAR) begin
      gen_ids.delete();
      gen_count = 0;
    end else if (cmd == CMD_INSERT && gen_count < DEPTH) begin
      gen_ids.push_back(id);
      gen_count++;
    end
  endtask

  task automatic run_phase(input bit hold, input int max_ops);
    int n_ops;
    int r;
    bit h;
    h = hold;
    if ($urandom_range(0, 4) != 0 || gen_count > 200) begin
      add_cmd(CMD_CLEAR, $urandom, h);
      h = 1'b0;
    end
    n_ops = $urandom_range(4, max_ops);
    for (int k = 0; k < n_ops; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) add_cmd(CMD_INSERT, pick_id(), h);
      else if (r < 95) add_cmd(CMD_LOOKUP, pick_id(), h);
      else if (r < 97) add_cmd(CMD_UNUSED, $urandom, h);
      else add_cmd(CMD_CLEAR, $urandom, h);
      h = 1'b0;
    end
  endtask

  // fill the table to the top, then knock on it while full
  task automatic fill_table();
    add_cmd(CMD_CLEAR, $urandom, 1'b1);
    for (int k = 0; k < DEPTH; k++)
      add_cmd(CMD_INSERT, $urandom_range(0, 1) ? pick_id() : $urandom);
    add_cmd(CMD_INSERT, pick_id(), 1'b1);
    add_cmd(CMD_INSERT, 32'h0000_0000);
    add_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    for (int k = 0; k < 24; k++) add_cmd(CMD_LOOKUP, pick_id());
    add_cmd(CMD_UNUSED, $urandom);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on response %0d: %s got %0d expected %0d", responses_seen, what, got,
             want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    table_cmd_t nxt;
    logic       nv;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        pending_responses.push_back(table_response(in_data));
        nv = 1'b0;
        send_gap = send_quiet ? 0 : draw_gap();
        if ($urandom_range(0, 149) == 0) send_quiet = !send_quiet;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_cmds.size() != 0 &&
                     !(queued_cmds[0].hold && pending_responses.size() != 0)) begin
          nxt = queued_cmds.pop_front();
          nv = 1'b1;
          in_data <= nxt.data;
        end
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_data_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        responses_seen++;
        if (pending_responses.size() == 0) begin
          report_mismatch("unexpected transaction, entry_index", out_data.entry_index, -1);
        end else begin
          want = pending_responses.pop_front();
          if (out_data.entry_index !== want.entry_index)
            report_mismatch("entry_index", out_data.entry_index, want.entry_index);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
        if ($urandom_range(0, 149) == 0) recv_quiet = !recv_quiet;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 3) == 0) recv_stall = draw_gap();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    idle_cycles = 0;
    mismatches = 0;
    responses_seen = 0;
    items_made = 0;
    gen_count = 0;
    tbl_count = 0;

    // directed: empty table, extremes, duplicates, misses on both sides, unused code
    add_cmd(CMD_LOOKUP, 32'h0000_0000);
    add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    add_cmd(CMD_INSERT, 32'h0000_0000);
    add_cmd(CMD_INSERT, 32'h8000_0000);
    add_cmd(CMD_LOOKUP, 32'h8000_0000);
    add_cmd(CMD_LOOKUP, 32'h0000_0000);
    add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF);
    add_cmd(CMD_LOOKUP, 32'h7FFF_FFFF);
    add_cmd(CMD_UNUSED, 32'h5555_5555);
    add_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
    add_cmd(CMD_LOOKUP, 32'h8000_0000);
    add_cmd(CMD_INSERT, 32'h0000_0010);
    add_cmd(CMD_INSERT, 32'h0000_0005);
    add_cmd(CMD_LOOKUP, 32'h0000_0001);
    add_cmd(CMD_LOOKUP, 32'h0000_0011);
    add_cmd(CMD_LOOKUP, 32'h0000_0005);
    add_cmd(CMD_UNUSED, 32'hAAAA_AAAA);
    add_cmd(CMD_CLEAR, 32'h0000_0000);

    phase = 0;
    while (items_made < RANDOM_ITEMS) begin
      phase++;
      if (phase == 4) fill_table();
      else run_phase(phase % 5 == 0, (phase % 7 == 0) ? 120 : 40);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (queued_cmds.size() != 0 || in_valid || pending_responses.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
